// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg
// Widths, pipeline stage numbers and cofactor index table of the 3x3 inverter
// ----------------------------------------------------------------------------
package m3i_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned FRAC_BITS = 16;

  // intermediate widths
  localparam int unsigned PROD_W = 2 * WORD_BITS;
  localparam int unsigned ADJ_W  = 2 * WORD_BITS + 1;
  localparam int unsigned PP_W   = 2 * WORD_BITS + 1;
  localparam int unsigned DET_W  = 3 * WORD_BITS + 3;
  localparam int unsigned NUM_W  = ADJ_W + 2 * FRAC_BITS;
  localparam int unsigned TOP_W  = NUM_W - WORD_BITS;
  localparam int unsigned CMP_W  = (TOP_W > DET_W) ? TOP_W : DET_W;

  // pipeline stage numbers
  localparam int unsigned S_PROD = 1;
  localparam int unsigned S_ADJ  = 2;
  localparam int unsigned S_DPP  = 3;
  localparam int unsigned S_DET  = 4;
  localparam int unsigned S_MAG  = 5;
  localparam int unsigned S_INIT = 6;
  localparam int unsigned S_OUT  = S_INIT + WORD_BITS + 1;
  localparam int unsigned NSTG   = S_OUT;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [ADJ_W-1:0]     adj_t;
  typedef logic signed [PP_W-1:0]      pp_t;
  typedef logic signed [DET_W-1:0]     det_t;
  typedef logic        [DET_W-1:0]     dmag_t;
  typedef logic        [ADJ_W-1:0]     amag_t;

  // adjugate entry k = m[a]*m[b] - m[c]*m[d], entries row major
  localparam logic [3:0] ADJ_IDX [9][4] = '{
    '{4'd4, 4'd8, 4'd7, 4'd5}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd3, 4'd2, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd6, 4'd4}, '{4'd6, 4'd1, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd3, 4'd1}
  };

endpackage

// File: hw/rtl/m3i_div_lane.sv
// ----------------------------------------------------------------------------
// m3i_div_lane
// Pipelined restoring divider for one entry: |adj| << 2*FRAC_BITS over |det|,
// one quotient bit per stage, with a quotient-too-large flag
// ----------------------------------------------------------------------------
module m3i_div_lane (
  input  logic                            clk_i,
  input  logic [m3i_pkg::WORD_BITS:0]     en_i,
  input  m3i_pkg::amag_t                  amag_i,
  input  m3i_pkg::dmag_t                  dmag_i,
  input  m3i_pkg::dmag_t                  dline_i [m3i_pkg::WORD_BITS],
  output logic [m3i_pkg::WORD_BITS-1:0]   q_o,
  output logic                            sat_o
);
  import m3i_pkg::*;

  logic [NUM_W-1:0]     num;
  logic [CMP_W-1:0]     top_ext;
  logic [CMP_W-1:0]     dmag_ext;

  dmag_t                r_q   [WORD_BITS+1];
  logic [WORD_BITS-1:0] nlo_q [WORD_BITS+1];
  logic [WORD_BITS-1:0] q_q   [WORD_BITS+1];
  logic                 sat_q [WORD_BITS+1];

  dmag_t                r_d   [1:WORD_BITS];
  logic [WORD_BITS-1:0] q_d   [1:WORD_BITS];

  // first stage: high part of the numerator becomes the remainder
  assign num      = {amag_i, {(2 * FRAC_BITS){1'b0}}};
  assign top_ext  = CMP_W'(num[NUM_W-1:WORD_BITS]);
  assign dmag_ext = CMP_W'(dmag_i);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sat_q[0] <= (top_ext >= dmag_ext);
      r_q[0]   <= top_ext[DET_W-1:0];
      nlo_q[0] <= num[WORD_BITS-1:0];
      q_q[0]   <= '0;
    end
  end

  // one trial subtract per stage
  always_comb begin
    logic [DET_W:0] t;
    for (int j = 1; j <= WORD_BITS; j++) begin
      t = {r_q[j-1], nlo_q[j-1][WORD_BITS-1]};
      if (t >= {1'b0, dline_i[j-1]}) begin
        r_d[j] = DET_W'(t - {1'b0, dline_i[j-1]});
        q_d[j] = {q_q[j-1][WORD_BITS-2:0], 1'b1};
      end else begin
        r_d[j] = t[DET_W-1:0];
        q_d[j] = {q_q[j-1][WORD_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 1; j <= WORD_BITS; j++) begin
      if (en_i[j]) begin
        r_q[j]   <= r_d[j];
        q_q[j]   <= q_d[j];
        nlo_q[j] <= {nlo_q[j-1][WORD_BITS-2:0], 1'b0};
        sat_q[j] <= sat_q[j-1];
      end
    end
  end

  assign q_o   = q_q[WORD_BITS];
  assign sat_o = sat_q[WORD_BITS];

endmodule

// File: hw/rtl/matrix3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3_inverse
// Inverse of a 3x3 signed fixed-point matrix by adjugate over determinant
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                        | tuser
//  s_axis   | in  | m00..m22, 32 bits each       | -
//  m_axis   | out | inv00..inv22, 32 bits each   | singular, overflow
//
//  one item per cycle sustained while m_axis_tready is high; the divider takes
//  one quotient bit per stage
//  rst_ni clears only the stage valid bits; no clearing pass
//  each stage holds while the one after it is full and stalled, so bubbles
//  close up and a stall loses or repeats no item
// ----------------------------------------------------------------------------
module matrix3_inverse (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [287:0] s_axis_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [287:0] m_axis_tdata,   // inv00, inv01, ..., inv22
  output logic [1:0]   m_axis_tuser    // singular, overflow
);
  import m3i_pkg::*;

  localparam word_t MAX_V = word_t'({1'b0, {(WORD_BITS-1){1'b1}}});
  localparam word_t MIN_V = word_t'({1'b1, {(WORD_BITS-1){1'b0}}});
  localparam logic [WORD_BITS-1:0] LIM = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic [NSTG+1:1] ready;
  logic [NSTG:1]   v_q;
  logic [NSTG:1]   v_in;

  // stage valid chain and ready ripple
  always_comb begin
    ready[NSTG+1] = m_axis_tready;
    for (int s = NSTG; s >= 1; s--) ready[s] = !v_q[s] || ready[s+1];
    v_in[1] = s_axis_tvalid;
    for (int s = 2; s <= NSTG; s++) v_in[s] = v_q[s-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 1; s <= NSTG; s++) if (ready[s]) v_q[s] <= v_in[s];
    end
  end

  assign s_axis_tready = ready[1];

  // unpack entries
  word_t m [9];
  always_comb begin
    for (int k = 0; k < 9; k++) m[k] = word_t'(s_axis_tdata[k*WORD_BITS +: WORD_BITS]);
  end

  // stage 1: cofactor products
  prod_t pa_q [9];
  prod_t pb_q [9];
  word_t mc1_q [3];
  always_ff @(posedge clk_i) begin
    if (ready[S_PROD]) begin
      for (int k = 0; k < 9; k++) begin
        pa_q[k] <= m[ADJ_IDX[k][0]] * m[ADJ_IDX[k][1]];
        pb_q[k] <= m[ADJ_IDX[k][2]] * m[ADJ_IDX[k][3]];
      end
      for (int i = 0; i < 3; i++) mc1_q[i] <= m[3*i];
    end
  end

  // stage 2: adjugate entries
  adj_t  adj2_q [9];
  word_t mc2_q [3];
  always_ff @(posedge clk_i) begin
    if (ready[S_ADJ]) begin
      for (int k = 0; k < 9; k++) adj2_q[k] <= ADJ_W'(pa_q[k]) - ADJ_W'(pb_q[k]);
      mc2_q <= mc1_q;
    end
  end

  // stage 3: determinant partial products, adjugate split into low and high halves
  pp_t  ppl_q [3];
  pp_t  pph_q [3];
  adj_t adj3_q [9];
  always_ff @(posedge clk_i) begin
    if (ready[S_DPP]) begin
      for (int i = 0; i < 3; i++) begin
        ppl_q[i] <= mc2_q[i] * $signed({1'b0, adj2_q[i][WORD_BITS-1:0]});
        pph_q[i] <= mc2_q[i] * $signed(adj2_q[i][ADJ_W-1:WORD_BITS]);
      end
      adj3_q <= adj2_q;
    end
  end

  // stage 4: determinant sum
  det_t det_d;
  det_t det_q;
  adj_t adj4_q [9];
  always_comb begin
    det_d = '0;
    for (int i = 0; i < 3; i++) det_d = det_d + (DET_W'(pph_q[i]) <<< WORD_BITS) + DET_W'(ppl_q[i]);
  end

  always_ff @(posedge clk_i) begin
    if (ready[S_DET]) begin
      det_q  <= det_d;
      adj4_q <= adj3_q;
    end
  end

  // stage 5: magnitudes and result signs
  dmag_t      dmag_q;
  logic       dzero_q;
  amag_t      amag_q [9];
  logic [8:0] neg_q;
  always_ff @(posedge clk_i) begin
    if (ready[S_MAG]) begin
      dmag_q  <= det_q[DET_W-1] ? dmag_t'(-det_q) : dmag_t'(det_q);
      dzero_q <= (det_q == '0);
      for (int k = 0; k < 9; k++) begin
        amag_q[k] <= adj4_q[k][ADJ_W-1] ? amag_t'(-adj4_q[k]) : amag_t'(adj4_q[k]);
        neg_q[k]  <= adj4_q[k][ADJ_W-1] ^ det_q[DET_W-1];
      end
    end
  end

  // divisor, sign and zero lines alongside the divider stages
  dmag_t      dline_q [WORD_BITS];
  logic [8:0] negl_q  [WORD_BITS+1];
  logic       zl_q    [WORD_BITS+1];
  always_ff @(posedge clk_i) begin
    if (ready[S_INIT]) begin
      dline_q[0] <= dmag_q;
      negl_q[0]  <= neg_q;
      zl_q[0]    <= dzero_q;
    end
    for (int j = 1; j <= WORD_BITS; j++) begin
      if (ready[S_INIT+j]) begin
        if (j < WORD_BITS) dline_q[j] <= dline_q[j-1];
        negl_q[j] <= negl_q[j-1];
        zl_q[j]   <= zl_q[j-1];
      end
    end
  end

  // nine divider lanes
  logic [WORD_BITS-1:0] q    [9];
  logic [8:0]           sat;
  for (genvar k = 0; k < 9; k++) begin : g_lane
    m3i_div_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (ready[S_INIT +: WORD_BITS+1]),
      .amag_i  (amag_q[k]),
      .dmag_i  (dmag_q),
      .dline_i (dline_q),
      .q_o     (q[k]),
      .sat_o   (sat[k])
    );
  end

  // output stage: sign, saturation, singular case
  logic [287:0] tdata_d;
  logic [1:0]   tuser_d;
  always_comb begin
    logic       ovf;
    logic       ng;
    word_t      val;
    ovf = 1'b0;
    for (int k = 0; k < 9; k++) begin
      ng = negl_q[WORD_BITS][k];
      if (zl_q[WORD_BITS]) begin
        val = '0;
      end else if (sat[k] || (!ng && q[k][WORD_BITS-1]) || (ng && q[k] > LIM)) begin
        val = ng ? MIN_V : MAX_V;
        ovf = 1'b1;
      end else begin
        val = ng ? word_t'(-q[k]) : word_t'(q[k]);
      end
      tdata_d[k*WORD_BITS +: WORD_BITS] = val;
    end
    tuser_d = {ovf, zl_q[WORD_BITS]};
  end

  always_ff @(posedge clk_i) begin
    if (ready[S_OUT]) begin
      m_axis_tdata <= tdata_d;
      m_axis_tuser <= tuser_d;
    end
  end

  assign m_axis_tvalid = v_q[S_OUT];

endmodule

// File: hw/rtl/m3i_checker.sv
// ----------------------------------------------------------------------------
// m3i_checker
// Port-level checks on the 3x3 inverter, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module m3i_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [287:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  // singular result carries an all-zero matrix
  `ASSERT_IMPL(a_sing_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0)

  // singular and overflow never together
  `ASSERT_IMPL(a_flags_excl, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]))

  // a free-running output never back-pressures the input
  `ASSERT_IMPL(a_ready_flow, m_axis_tready, s_axis_tready)

  // a stalled item holds
  `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
               m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind matrix3_inverse m3i_checker u_m3i_checker (.*);
